### hdl/brc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and codes of the block range coalescer: input modes, result
// status codes, the stored entry layout, the result word and the sequencer
// states.
// ----------------------------------------------------------------------------
package brc_pkg;

   // Input modes.
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_MERGE = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_APPENDED  = 3'd0;
   localparam logic [2:0] STAT_MERGED    = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_SATURATED = 3'd3;
   localparam logic [2:0] STAT_EMITTED   = 3'd4;
   localparam logic [2:0] STAT_EMPTY     = 3'd5;

   localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

   // One table entry as it is held in the entry memory.
   typedef struct packed {
      logic [63:0] offset;
      logic [31:0] length;
      logic        flag;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic [63:0] offset;
      logic [31:0] length;
      logic        changed;
      logic [2:0]  status;
      logic        last;
   } rslt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_APPEND,
      ST_EMIT,
      ST_EMPTY
   } state_type;

endpackage
`default_nettype wire

### hdl/block_range_coalescer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_range_coalescer
// Table of block ranges held in one entry memory. Loads append ranges,
// merges extend the first entry that holds a new range's start (or append
// when none does), and a flush emits the table sorted by offset, then empties it.
// ----------------------------------------------------------------------------
//
//  Channel | Ports  | Direction | Word
//  --------+--------+-----------+---------------------------------------------
//  request | req_*  | in        | mode, range offset, length, changed mark
//  result  | rsp_*  | out       | offset, length, changed, status, last
//
// A merge scans the entry memory in insertion order at one entry a cycle
// through its one read port and stops at the first entry that matches;
// when none matches, the range is appended. A flush of n entries runs n
// minimum-search passes over the memory, each followed by emitting the
// smallest entry not yet emitted; an empty flush returns a single empty
// status word.
// Reset is synchronous and clears the entry count, the sequencer and the
// result valid; the memory needs no clearing pass because only entries below
// the count are read. The result goes to an output register, so a new request
// word is accepted while the previous result waits; the sequencer stalls only
// when it has a new result word and that register is still held by rsp_ready low.
//
module block_range_coalescer #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [63:0] req_range_offset,
   input  wire logic [31:0] req_range_length,
   input  wire logic        req_range_changed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_out_offset,
   output logic [31:0]      rsp_out_length,
   output logic             rsp_out_changed,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);

   import brc_pkg::*;

   // Index width of the entry memory, and a count width that can hold the depth.
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic          slot_free;
   logic          emit_valid;
   rslt_type      emit_word;
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   entry_type     ram_wdata;
   logic          ram_re;
   logic [IW-1:0] ram_raddr;
   entry_type     ram_rdata;
   logic [$bits(entry_type)-1:0] ram_rbits;

   logic          rsp_valid_ff, rsp_valid_in;
   rslt_type      rsp_word_ff, rsp_word_in;

   brc_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IW          (IW),
      .CW          (CW)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_range_offset  (req_range_offset),
      .req_range_length  (req_range_length),
      .req_range_changed (req_range_changed),
      .slot_free         (slot_free),
      .emit_valid        (emit_valid),
      .emit_word         (emit_word),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_re            (ram_re),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata)
   );

   // Entry memory: offset, length and changed flag of every table entry.
   brc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH),
      .AW    (IW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   // The output register may take a new word when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_offset  = rsp_word_ff.offset;
   assign rsp_out_length  = rsp_word_ff.length;
   assign rsp_out_changed = rsp_word_ff.changed;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_last        = rsp_word_ff.last;

endmodule
`default_nettype wire

### hdl/brc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module brc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/brc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brc_engine
// Sequencer of the coalescer: scans the entry memory for merges, appends
// ranges, and runs repeated minimum-search passes to emit a sorted flush.
// ----------------------------------------------------------------------------
module brc_engine #(
   parameter int TABLE_DEPTH = 16,
   parameter int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [63:0]       req_range_offset,
   input  wire logic [31:0]       req_range_length,
   input  wire logic              req_range_changed,
   input  wire logic              slot_free,
   output logic                   emit_valid,
   output brc_pkg::rslt_type      emit_word,
   output logic                   ram_we,
   output logic [IW-1:0]          ram_waddr,
   output brc_pkg::entry_type     ram_wdata,
   output logic                   ram_re,
   output logic [IW-1:0]          ram_raddr,
   input  wire brc_pkg::entry_type ram_rdata
);

   import brc_pkg::*;

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic        is_flush_ff, is_flush_in;
   logic [63:0] off_ff, off_in;
   logic [31:0] len_ff, len_in;
   logic        chg_ff, chg_in;
   logic [IW-1:0] m_idx_ff, m_idx_in;
   entry_type   m_ent_ff, m_ent_in;
   logic [31:0] m_diff_ff, m_diff_in;
   logic        best_vld_ff, best_vld_in;
   entry_type   best_ent_ff, best_ent_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic        have_prev_ff, have_prev_in;
   logic [63:0] prev_off_ff, prev_off_in;
   logic [IW-1:0] prev_idx_ff, prev_idx_in;
   logic [CW-1:0] emit_ff, emit_in;

   always_comb begin
      logic [64:0] diff;
      logic        hold;
      logic        cand;
      logic        better;
      logic [32:0] reach;
      logic [31:0] nlen;
      logic        is_last;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      is_flush_in  = is_flush_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      chg_in       = chg_ff;
      m_idx_in     = m_idx_ff;
      m_ent_in     = m_ent_ff;
      m_diff_in    = m_diff_ff;
      best_vld_in  = best_vld_ff;
      best_ent_in  = best_ent_ff;
      best_idx_in  = best_idx_ff;
      have_prev_in = have_prev_ff;
      prev_off_in  = prev_off_ff;
      prev_idx_in  = prev_idx_ff;
      emit_in      = emit_ff;

      req_ready  = 1'b0;
      emit_valid = 1'b0;
      emit_word  = '0;
      ram_we     = 1'b0;
      ram_waddr  = cnt_ff[IW-1:0];
      ram_wdata  = '0;
      ram_re     = 1'b0;
      ram_raddr  = iss_ff[IW-1:0];

      // The entry holds the start when the exact difference is below its length.
      diff   = {1'b0, off_ff} - {1'b0, ram_rdata.offset};
      hold   = !diff[64] && (diff[63:32] == 32'd0) && (diff[31:0] < ram_rdata.length);
      // Flush order key is offset then insertion index.
      cand   = !have_prev_ff || ({ram_rdata.offset, chk_idx_ff} > {prev_off_ff, prev_idx_ff});
      better = !best_vld_ff || ({ram_rdata.offset, chk_idx_ff} < {best_ent_ff.offset, best_idx_ff});

      reach   = {1'b0, m_diff_ff} + {1'b0, len_ff};
      nlen    = reach[32] ? LEN_MAX :
                ((reach[31:0] > m_ent_ff.length) ? reach[31:0] : m_ent_ff.length);
      is_last = ((emit_ff + CW'(1)) == cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               off_in      = req_range_offset;
               len_in      = req_range_length;
               chg_in      = req_range_changed;
               iss_in      = '0;
               chk_vld_in  = 1'b0;
               best_vld_in = 1'b0;
               case (req_mode)
                  MODE_LOAD: begin
                     state_in = ST_APPEND;
                  end
                  MODE_MERGE: begin
                     is_flush_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  MODE_FLUSH: begin
                     if (cnt_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        is_flush_in  = 1'b1;
                        have_prev_in = 1'b0;
                        emit_in      = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (iss_ff < cnt_ff) begin
               ram_re     = 1'b1;
               iss_in     = iss_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IW-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if (!is_flush_ff) begin
                  if (hold) begin
                     m_idx_in  = chk_idx_ff;
                     m_ent_in  = ram_rdata;
                     m_diff_in = diff[31:0];
                     state_in  = ST_MERGE;
                  end
               end else if (cand && better) begin
                  best_vld_in = 1'b1;
                  best_ent_in = ram_rdata;
                  best_idx_in = chk_idx_ff;
               end
            end else if (iss_ff >= cnt_ff) begin
               state_in = is_flush_ff ? ST_EMIT : ST_APPEND;
            end
         end

         ST_MERGE: begin
            if (slot_free) begin
               ram_we            = 1'b1;
               ram_waddr         = m_idx_ff;
               ram_wdata.offset  = m_ent_ff.offset;
               ram_wdata.length  = nlen;
               ram_wdata.flag    = m_ent_ff.flag;
               emit_valid        = 1'b1;
               emit_word.offset  = m_ent_ff.offset;
               emit_word.length  = nlen;
               emit_word.changed = m_ent_ff.flag;
               emit_word.status  = reach[32] ? STAT_SATURATED : STAT_MERGED;
               emit_word.last    = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_APPEND: begin
            if (slot_free) begin
               emit_valid        = 1'b1;
               emit_word.offset  = off_ff;
               emit_word.length  = len_ff;
               emit_word.changed = chg_ff;
               emit_word.last    = 1'b1;
               if (cnt_ff == CW'(TABLE_DEPTH)) begin
                  emit_word.status = STAT_FULL;
               end else begin
                  emit_word.status = STAT_APPENDED;
                  ram_we           = 1'b1;
                  ram_wdata.offset = off_ff;
                  ram_wdata.length = len_ff;
                  ram_wdata.flag   = chg_ff;
                  cnt_in           = cnt_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               emit_valid        = 1'b1;
               emit_word.offset  = best_ent_ff.offset;
               emit_word.length  = best_ent_ff.length;
               emit_word.changed = best_ent_ff.flag;
               emit_word.status  = STAT_EMITTED;
               emit_word.last    = is_last;
               have_prev_in      = 1'b1;
               prev_off_in       = best_ent_ff.offset;
               prev_idx_in       = best_idx_ff;
               emit_in           = emit_ff + CW'(1);
               if (is_last) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  iss_in      = '0;
                  chk_vld_in  = 1'b0;
                  best_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_EMPTY: begin
            if (slot_free) begin
               emit_valid       = 1'b1;
               emit_word.status = STAT_EMPTY;
               emit_word.last   = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         emit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         best_vld_ff  <= best_vld_in;
         have_prev_ff <= have_prev_in;
         emit_ff      <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      is_flush_ff <= is_flush_in;
      off_ff      <= off_in;
      len_ff      <= len_in;
      chg_ff      <= chg_in;
      m_idx_ff    <= m_idx_in;
      m_ent_ff    <= m_ent_in;
      m_diff_ff   <= m_diff_in;
      best_ent_ff <= best_ent_in;
      best_idx_ff <= best_idx_in;
      prev_off_ff <= prev_off_in;
      prev_idx_ff <= prev_idx_in;
   end

endmodule
`default_nettype wire

### tb/brc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brc_result_checker
// Watches both channels of the block range coalescer, keeps its own copy of
// the range table, works out the result words of every accepted request
// word and compares them, field by field and in order, with the words that
// leave the block.
// ----------------------------------------------------------------------------
module brc_result_checker
   import brc_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_range_offset,
   input  logic [31:0] req_range_length,
   input  logic        req_range_changed,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_out_offset,
   input  logic [31:0] rsp_out_length,
   input  logic        rsp_out_changed,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_last,
   output int          fail_count,
   output int          outstanding,
   output int          words_in,
   output int          words_out,
   output int          flushes,
   output int          merges,
   output int          saturations,
   output int          drops
);

   logic [63:0] tbl_off  [DEPTH];
   logic [31:0] tbl_len  [DEPTH];
   logic        tbl_flag [DEPTH];
   int          tbl_count = 0;

   rslt_type    expected_words[$];

   int fails = 0;
   int n_in = 0, n_out = 0, n_flush = 0, n_merge = 0, n_sat = 0, n_drop = 0;

   function automatic void expect_word(logic [63:0] off, logic [31:0] len, logic chg,
                                       logic [2:0] status, logic last);
      rslt_type w;
      w.offset  = off;
      w.length  = len;
      w.changed = chg;
      w.status  = status;
      w.last    = last;
      expected_words = {expected_words, w};
      case (status)
         STAT_MERGED:    n_merge++;
         STAT_SATURATED: begin
            n_merge++;
            n_sat++;
         end
         STAT_FULL:      n_drop++;
         default:        ;
      endcase
   endfunction

   function automatic void append_range(logic [63:0] off, logic [31:0] len, logic chg);
      if (tbl_count >= DEPTH) begin
         expect_word(off, len, chg, STAT_FULL, 1'b1);
      end else begin
         tbl_off[tbl_count]  = off;
         tbl_len[tbl_count]  = len;
         tbl_flag[tbl_count] = chg;
         tbl_count++;
         expect_word(off, len, chg, STAT_APPENDED, 1'b1);
      end
   endfunction

   // Merge: first entry in insertion order whose span holds the new start.
   // The reach is worked out one bit wider so that it never wraps.
   function automatic void merge_range(logic [63:0] off, logic [31:0] len, logic chg);
      logic [63:0] delta;
      logic [64:0] grown;
      logic [2:0]  status;
      bit          hit;
      hit = 1'b0;
      for (int i = 0; i < tbl_count && !hit; i++) begin
         delta = off - tbl_off[i];
         if (off >= tbl_off[i] && delta < {32'd0, tbl_len[i]}) begin
            hit   = 1'b1;
            grown = {1'b0, delta} + {33'd0, len};
            if (grown < {33'd0, tbl_len[i]})
               grown = {33'd0, tbl_len[i]};
            status = STAT_MERGED;
            if (grown > {33'd0, LEN_MAX}) begin
               grown  = {33'd0, LEN_MAX};
               status = STAT_SATURATED;
            end
            tbl_len[i] = grown[31:0];
            expect_word(tbl_off[i], grown[31:0], tbl_flag[i], status, 1'b1);
         end
      end
      if (!hit)
         append_range(off, len, chg);
   endfunction

   // Flush: stable insertion sort by offset, then every entry goes out.
   function automatic void flush_table();
      int order[DEPTH];
      int j;
      n_flush++;
      if (tbl_count == 0) begin
         expect_word('0, '0, 1'b0, STAT_EMPTY, 1'b1);
      end else begin
         for (int i = 0; i < tbl_count; i++) begin
            j = i;
            while (j > 0 && tbl_off[order[j-1]] > tbl_off[i]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (int i = 0; i < tbl_count; i++)
            expect_word(tbl_off[order[i]], tbl_len[order[i]], tbl_flag[order[i]],
                        STAT_EMITTED, i == tbl_count - 1);
         tbl_count = 0;
      end
   endfunction

   function automatic void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         if (fails < 40)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      rslt_type want;
      if (reset) begin
         tbl_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_out++;
            if (expected_words.size() == 0) begin
               if (fails < 40)
                  $display("%0t ns: unexpected result word, expected none, actual %h %h %0d",
                           $time, rsp_out_offset, rsp_out_length, rsp_status);
               fails++;
            end else begin
               want = expected_words.pop_front();
               report_field("offset",  want.offset,  rsp_out_offset);
               report_field("length",  want.length,  rsp_out_length);
               report_field("changed", want.changed, rsp_out_changed);
               report_field("status",  want.status,  rsp_status);
               report_field("last",    want.last,    rsp_last);
            end
         end
         if (req_valid && req_ready) begin
            n_in++;
            case (req_mode)
               MODE_LOAD:  append_range(req_range_offset, req_range_length, req_range_changed);
               MODE_MERGE: merge_range(req_range_offset, req_range_length, req_range_changed);
               MODE_FLUSH: flush_table();
               default:    ;
            endcase
         end
      end
      fail_count  <= fails;
      outstanding <= expected_words.size();
      words_in    <= n_in;
      words_out   <= n_out;
      flushes     <= n_flush;
      merges      <= n_merge;
      saturations <= n_sat;
      drops       <= n_drop;
   end

endmodule

### tb/tb_block_range_coalescer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_range_coalescer
// Drives request words into the block range coalescer and takes its result
// words with random gaps on both sides, then reports the verdict. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_block_range_coalescer;
   import brc_pkg::*;

   localparam int TABLE_DEPTH = 16;

   // The block ignores this mode, so the package gives it no name.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Number of request words (ignored ones not counted) before the run ends.
   localparam int N_WORDS = 400;

   // The sender stops idling for this window of request words.
   localparam int SENDER_CALM_FIRST = 150;
   localparam int SENDER_CALM_LAST  = 230;

   // Receiver timeline, counted in its own cycles after reset: one long
   // hold-off so that the block backs up into its request port, and a long
   // window with rsp_ready held high.
   localparam int HOLD_START     = 1500;
   localparam int HOLD_CYCLES    = 400;
   localparam int RX_CALM_START  = 3000;
   localparam int RX_CALM_END    = 5000;

   // The watchdog is set well above a full-table flush and the receiver
   // hold-off, and the drain wait above a full-table flush.
   localparam int DRAIN_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_LOAD;
   logic [63:0] req_range_offset = '0;
   logic [31:0] req_range_length = '0;
   logic        req_range_changed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_offset;
   logic [31:0] rsp_out_length;
   logic        rsp_out_changed;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   int fail_count, outstanding, words_in, words_out;
   int flushes, merges, saturations, drops;

   int words_sent = 0;
   int rx_cycle = 0;
   int quiet_cycles = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   block_range_coalescer #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_range_offset  (req_range_offset),
      .req_range_length  (req_range_length),
      .req_range_changed (req_range_changed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_changed   (rsp_out_changed),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   brc_result_checker #(
      .DEPTH(TABLE_DEPTH)
   ) result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_range_offset  (req_range_offset),
      .req_range_length  (req_range_length),
      .req_range_changed (req_range_changed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_changed   (rsp_out_changed),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .words_in          (words_in),
      .words_out         (words_out),
      .flushes           (flushes),
      .merges            (merges),
      .saturations       (saturations),
      .drops             (drops)
   );

   // Offers one request word and returns once it has been accepted. A gap
   // may come first, during which valid is low; once valid is raised it
   // stays up with the same payload until the block takes the word.
   task automatic send_word(input logic [1:0] mode, input logic [63:0] off,
                            input logic [31:0] len, input logic chg);
      int gap;
      gap = 0;
      if ((words_sent < SENDER_CALM_FIRST || words_sent >= SENDER_CALM_LAST) &&
          $urandom_range(0, 99) < 25)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_range_offset  <= off;
      req_range_length  <= len;
      req_range_changed <= chg;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (mode != MODE_UNUSED)
         words_sent++;
   endtask

   // Lengths lean towards small spans so that merges find their entries, with
   // zero-length ranges, lengths close to the top and fully random ones mixed
   // in to reach saturation and every length bit.
   function automatic logic [31:0] random_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return '0;
      else if (roll < 20)
         return LEN_MAX - $urandom_range(0, 300);
      else if (roll < 35)
         return $urandom;
      else
         return $urandom_range(1, 600);
   endfunction

   // Receiver side. Ready follows its own cycle count: random stalls, one
   // long hold-off while the sender keeps offering words, and one long
   // stretch with no stalls at all.
   always @(posedge clock) begin
      if (reset) begin
         rx_cycle  <= 0;
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_END)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 99) >= 25);
      end
   end

   // Watchdog: any cycle in which neither channel moves a word counts toward
   // the limit; a handshake on either side starts the count again.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles, %0d result words outstanding",
                  $time, WATCHDOG_LIMIT, outstanding);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] base;
      logic [63:0] off;
      logic [31:0] len;
      entry_type   aim;
      entry_type   seq_ranges[$];
      int          n_loads;
      int          n_merges;
      int          roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty flush comes first. A zero-length entry must
      // never hold a merge start, so the merge at offset zero appends. The
      // range at the very top of the offset space with the largest length
      // merges onto itself without saturating, while the merge that reaches
      // past the top of the length field saturates. An entry with an equal
      // offset checks that ties keep insertion order in the flush, and the
      // unused mode must change nothing.
      send_word(MODE_FLUSH, '0, '0, 1'b0);
      send_word(MODE_LOAD,  64'd0, 32'd0, 1'b0);
      send_word(MODE_MERGE, 64'd0, 32'd10, 1'b1);
      send_word(MODE_LOAD,  '1, LEN_MAX, 1'b1);
      send_word(MODE_MERGE, '1, LEN_MAX, 1'b0);
      send_word(MODE_LOAD,  64'd100, 32'd50, 1'b0);
      send_word(MODE_MERGE, 64'd149, LEN_MAX, 1'b1);
      send_word(MODE_LOAD,  64'd100, 32'd5, 1'b1);
      send_word(MODE_UNUSED, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 1'b1);

      // Fill the table with descending offsets so the flush has to sort,
      // then hit the full table with a load and a merge that finds nothing.
      // The merge start lies just past the saturated entry's span. A merge
      // that does find its entry still works on a full table.
      for (int k = 0; k < TABLE_DEPTH - 5; k++)
         send_word(MODE_LOAD, 64'd1000 - 10 * k, 32'd8, k[0]);
      send_word(MODE_LOAD,  64'd2000, 32'd16, 1'b1);
      send_word(MODE_MERGE, 64'h0000_0001_0000_1000, 32'd4, 1'b0);
      send_word(MODE_MERGE, 64'd105, 32'd3, 1'b0);
      send_word(MODE_FLUSH, '0, '0, 1'b0);

      // Random part: each sequence loads a base list near one region of the
      // offset space, runs merges that mostly land inside ranges already
      // sent, and ends with a flush. Stray words, early flushes and merges
      // anywhere in the offset space are mixed in as noise.
      while (words_sent < N_WORDS) begin
         roll = $urandom_range(0, 3);
         if (roll < 2)
            base = $urandom_range(0, 4095);
         else if (roll == 2)
            base = {$urandom, $urandom};
         else
            base = '1 - $urandom_range(0, 20000);
         seq_ranges.delete();

         n_loads = $urandom_range(0, TABLE_DEPTH + 2);
         for (int k = 0; k < n_loads; k++) begin
            aim.offset = base + $urandom_range(0, 3000);
            aim.length = random_length();
            aim.flag   = $urandom_range(0, 1);
            send_word(MODE_LOAD, aim.offset, aim.length, aim.flag);
            seq_ranges = {seq_ranges, aim};
         end

         n_merges = $urandom_range(1, 10);
         for (int k = 0; k < n_merges; k++) begin
            roll = $urandom_range(0, 99);
            len  = random_length();
            if (roll < 65 && seq_ranges.size() > 0) begin
               aim = seq_ranges[$urandom_range(0, seq_ranges.size() - 1)];
               off = aim.offset;
               if (aim.length != 0)
                  off = aim.offset + ($urandom % aim.length);
            end else if (roll < 88) begin
               off = base + $urandom_range(0, 4000);
            end else if (roll < 94) begin
               off = {$urandom, $urandom};
            end else if (roll < 97) begin
               send_word(MODE_UNUSED, {$urandom, $urandom}, $urandom, $urandom_range(0, 1));
               continue;
            end else begin
               send_word(MODE_FLUSH, {$urandom, $urandom}, $urandom, $urandom_range(0, 1));
               seq_ranges.delete();
               continue;
            end
            aim.offset = off;
            aim.length = len;
            aim.flag   = $urandom_range(0, 1);
            send_word(MODE_MERGE, off, len, aim.flag);
            seq_ranges = {seq_ranges, aim};
         end

         send_word(MODE_FLUSH, {$urandom, $urandom}, $urandom, $urandom_range(0, 1));
      end

      // Every word is in. Wait for the outstanding results, then give the
      // block time to show any stray word before the verdict.
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words, %0d of them flushes, and %0d result words.",
               words_in, flushes, words_out);
      $display("Merges %0d (%0d saturated), ranges dropped on a full table %0d.",
               merges, saturations, drops);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
